### hdl/i2cbs_pkg.sv
// Package for the I2C master bit sequencer.
// Holds the command and step transaction types, request codes and shared structs.
// No dependencies.
package i2cbs_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_IDX_W = $clog2(BITS_PER_BYTE);
	localparam int GROUP_W = $clog2(BITS_PER_BYTE + 1);
	localparam int PEND_W = 4;

	localparam logic [2:0] REQ_START = 3'd0;
	localparam logic [2:0] REQ_RSTART = 3'd1;
	localparam logic [2:0] REQ_STOP = 3'd2;
	localparam logic [2:0] REQ_WRITE = 3'd3;
	localparam logic [2:0] REQ_READ = 3'd4;
	localparam logic [2:0] REQ_SAMPLE = 3'd5;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic send_ack;
		logic sda_level;
	} cmd_t;

	typedef struct packed {
		logic scl_level;
		logic sda_pull_low;
		logic sample_request;
		logic step_last;
		logic rx_valid;
		logic [7:0] rx_byte;
		logic ack_seen;
	} step_t;

	typedef struct packed {
		logic [PEND_W-1:0] pending;
		logic expect_data;
		logic [7:0] shift;
	} rx_state_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic group_end;
	} step_ctl_t;

endpackage

### hdl/i2cbs_step_gen.sv
// Step decoder for the I2C master bit sequencer.
// Maps the held command, its bit group and phase, and the receive state to one step.
// Depends on i2cbs_pkg.
module i2cbs_step_gen (
	input  i2cbs_pkg::cmd_t                    cmd,
	input  logic [i2cbs_pkg::GROUP_W-1:0]      group,
	input  logic [1:0]                         phase,
	input  i2cbs_pkg::rx_state_t               rx,
	output i2cbs_pkg::step_t                   res,
	output i2cbs_pkg::step_ctl_t               ctl
);

	logic group_done;
	logic tx_group;
	logic rx_group;
	logic tx_low;
	logic [i2cbs_pkg::BIT_IDX_W-1:0] bit_idx;

	assign group_done = (group == i2cbs_pkg::GROUP_W'(i2cbs_pkg::BITS_PER_BYTE));
	assign bit_idx = i2cbs_pkg::BIT_IDX_W'(i2cbs_pkg::BITS_PER_BYTE - 1)
		- group[i2cbs_pkg::BIT_IDX_W-1:0];

	always_comb begin
		res = '0;
		ctl.emit = 1'b1;
		ctl.last = 1'b0;
		ctl.group_end = 1'b0;
		tx_group = 1'b0;
		rx_group = 1'b0;
		tx_low = 1'b0;
		case (cmd.req_type)
			i2cbs_pkg::REQ_START: begin
				res.scl_level = (phase != 2'd2);
				res.sda_pull_low = (phase != 2'd0);
				ctl.last = (phase == 2'd2);
			end
			i2cbs_pkg::REQ_RSTART: begin
				res.scl_level = (phase == 2'd1) || (phase == 2'd2);
				res.sda_pull_low = phase[1];
				ctl.last = (phase == 2'd3);
			end
			i2cbs_pkg::REQ_STOP: begin
				res.scl_level = (phase != 2'd0);
				res.sda_pull_low = (phase != 2'd2);
				ctl.last = (phase == 2'd2);
			end
			i2cbs_pkg::REQ_WRITE: begin
				if (!group_done) begin
					tx_group = 1'b1;
					tx_low = ~cmd.data_byte[bit_idx];
				end else begin
					rx_group = 1'b1;
				end
			end
			i2cbs_pkg::REQ_READ: begin
				if (!group_done) begin
					rx_group = 1'b1;
				end else begin
					tx_group = 1'b1;
					tx_low = cmd.send_ack;
				end
			end
			i2cbs_pkg::REQ_SAMPLE: begin
				ctl.last = 1'b1;
				ctl.emit = (rx.pending != '0)
					&& (!rx.expect_data || (rx.pending == i2cbs_pkg::PEND_W'(1)));
				res.rx_valid = 1'b1;
				if (rx.expect_data) begin
					res.rx_byte = {rx.shift[6:0], cmd.sda_level};
				end else begin
					res.ack_seen = ~cmd.sda_level;
				end
			end
			default: begin
				ctl.emit = 1'b0;
				ctl.last = 1'b1;
			end
		endcase

		if (tx_group) begin
			res.scl_level = (phase == 2'd1);
			res.sda_pull_low = tx_low;
			ctl.group_end = (phase == 2'd2);
		end
		if (rx_group) begin
			res.scl_level = (phase == 2'd1) || (phase == 2'd2);
			res.sample_request = (phase == 2'd2);
			ctl.group_end = (phase == 2'd3);
		end
		if (tx_group || rx_group) begin
			ctl.last = group_done && ctl.group_end;
		end
		res.step_last = ctl.last && (cmd.req_type != i2cbs_pkg::REQ_SAMPLE);
	end

endmodule

### hdl/i2cbs_rx_state.sv
// Receive collector state for the I2C master bit sequencer.
// Tracks pending samples, byte or ACK mode and the shift register, updated as commands retire.
// Depends on i2cbs_pkg.
module i2cbs_rx_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 retire,
	input  i2cbs_pkg::cmd_t      cmd,
	output i2cbs_pkg::rx_state_t rx
);

	i2cbs_pkg::rx_state_t rx_q;

	assign rx = rx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q <= '0;
		end else if (retire) begin
			case (cmd.req_type)
				i2cbs_pkg::REQ_WRITE: begin
					rx_q.pending <= i2cbs_pkg::PEND_W'(1);
					rx_q.expect_data <= 1'b0;
					rx_q.shift <= '0;
				end
				i2cbs_pkg::REQ_READ: begin
					rx_q.pending <= i2cbs_pkg::PEND_W'(i2cbs_pkg::BITS_PER_BYTE);
					rx_q.expect_data <= 1'b1;
					rx_q.shift <= '0;
				end
				i2cbs_pkg::REQ_SAMPLE: begin
					if (rx_q.pending != '0) begin
						if (rx_q.expect_data) begin
							rx_q.shift <= {rx_q.shift[6:0], cmd.sda_level};
							rx_q.pending <= rx_q.pending - i2cbs_pkg::PEND_W'(1);
						end else begin
							rx_q.pending <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/i2c_master_bit_sequencer.sv
// A command is taken into the command register; its steps go out through the output register,
// one step per cycle while the output is not stalled. Start, repeated start, stop, write and
// read have 3, 4, 3, 28 and 35 steps; a sample has one step or none, an unused code none.
// The next command is taken at the edge on which the last step of the current one is issued.
// Reset clears the valid flags, step counters and the receive collector state.
module i2c_master_bit_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  i2cbs_pkg::cmd_t   cmd,
	output logic              step_valid,
	input  logic              step_stall,
	output i2cbs_pkg::step_t  step
);

	i2cbs_pkg::cmd_t cmd_s1;
	logic cmd_valid_s1;
	logic [i2cbs_pkg::GROUP_W-1:0] group_s1;
	logic [1:0] phase_s1;

	i2cbs_pkg::step_t step_s2;
	logic step_valid_s2;

	i2cbs_pkg::rx_state_t rx;
	i2cbs_pkg::step_t res;
	i2cbs_pkg::step_ctl_t ctl;

	logic out_free;
	logic advance;
	logic retire;
	logic cmd_accept;

	i2cbs_step_gen u_step_gen (
		.cmd   (cmd_s1),
		.group (group_s1),
		.phase (phase_s1),
		.rx    (rx),
		.res   (res),
		.ctl   (ctl)
	);

	i2cbs_rx_state u_rx_state (
		.clk    (clk),
		.arst_n (arst_n),
		.retire (retire),
		.cmd    (cmd_s1),
		.rx     (rx)
	);

	assign out_free = !step_valid_s2 || !step_stall;
	assign advance = cmd_valid_s1 && (!ctl.emit || out_free);
	assign retire = advance && ctl.last;
	assign cmd_stall = cmd_valid_s1 && !retire;
	assign cmd_accept = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			group_s1 <= '0;
			phase_s1 <= '0;
		end else if (cmd_accept) begin
			cmd_valid_s1 <= 1'b1;
			group_s1 <= '0;
			phase_s1 <= '0;
		end else if (retire) begin
			cmd_valid_s1 <= 1'b0;
		end else if (advance) begin
			if (ctl.group_end) begin
				group_s1 <= group_s1 + i2cbs_pkg::GROUP_W'(1);
				phase_s1 <= '0;
			end else begin
				phase_s1 <= phase_s1 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_valid_s2 <= 1'b0;
		end else if (out_free) begin
			step_valid_s2 <= advance && ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && ctl.emit) begin
			step_s2 <= res;
		end
	end

	assign step_valid = step_valid_s2;
	assign step = step_s2;

endmodule

### hdl/i2cbs_checker.sv
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Checks output hold under stall and the field rules of sample, completion and pin steps.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer.
module i2cbs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             step_valid,
	input logic             step_stall,
	input i2cbs_pkg::step_t step
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_stall |=> step_valid && $stable(step))
		else $error("Step transaction changed while stalled.");

	a_sample: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step.sample_request |-> step.scl_level && !step.sda_pull_low
			&& !step.rx_valid)
		else $error("Sample request step has wrong pin levels.");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step.rx_valid |-> !step.scl_level && !step.sda_pull_low
			&& !step.sample_request && !step.step_last)
		else $error("Completion step carries pin activity.");

	a_pin: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && !step.rx_valid |-> (step.rx_byte == 8'd0) && !step.ack_seen)
		else $error("Pin step carries receive data.");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.step_valid (step_valid),
	.step_stall (step_stall),
	.step       (step)
);

### tb/i2c_master_bit_sequencer_tb.sv
// Self-checking testbench for the I2C master bit sequencer.
// Predicts every pin step and receive report from the commands it sends; depends on
// i2cbs_pkg and the i2c_master_bit_sequencer module.
module i2c_master_bit_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	class i2c_step_checker;
		i2cbs_pkg::step_t steps_due[$];
		logic [i2cbs_pkg::PEND_W-1:0] samples_left;
		bit collect_byte;
		logic [7:0] rx_bits;
		int mismatches;

		function new();
			samples_left = '0;
			collect_byte = 1'b0;
			rx_bits = '0;
			mismatches = 0;
		endfunction

		function void add(bit scl, bit pull, bit smp, bit last, bit rxv, logic [7:0] rxb,
				bit ack);
			i2cbs_pkg::step_t s;
			s.scl_level = scl;
			s.sda_pull_low = pull;
			s.sample_request = smp;
			s.step_last = last;
			s.rx_valid = rxv;
			s.rx_byte = rxb;
			s.ack_seen = ack;
			steps_due.insert(steps_due.size(), s);
		endfunction

		function void pin(bit scl, bit pull, bit last);
			add(scl, pull, 1'b0, last, 1'b0, 8'h00, 1'b0);
		endfunction

		// Returns 0 when the command is ignored by the block.
		function bit expand_command(i2cbs_pkg::cmd_t c);
			bit low;
			case (c.req_type)
				i2cbs_pkg::REQ_START: begin
					pin(1'b1, 1'b0, 1'b0);
					pin(1'b1, 1'b1, 1'b0);
					pin(1'b0, 1'b1, 1'b1);
				end
				i2cbs_pkg::REQ_RSTART: begin
					pin(1'b0, 1'b0, 1'b0);
					pin(1'b1, 1'b0, 1'b0);
					pin(1'b1, 1'b1, 1'b0);
					pin(1'b0, 1'b1, 1'b1);
				end
				i2cbs_pkg::REQ_STOP: begin
					pin(1'b0, 1'b1, 1'b0);
					pin(1'b1, 1'b1, 1'b0);
					pin(1'b1, 1'b0, 1'b1);
				end
				i2cbs_pkg::REQ_WRITE: begin
					for (int i = i2cbs_pkg::BITS_PER_BYTE - 1; i >= 0; i--) begin
						low = ~c.data_byte[i];
						pin(1'b0, low, 1'b0);
						pin(1'b1, low, 1'b0);
						pin(1'b0, low, 1'b0);
					end
					pin(1'b0, 1'b0, 1'b0);
					pin(1'b1, 1'b0, 1'b0);
					add(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
					pin(1'b0, 1'b0, 1'b1);
					samples_left = i2cbs_pkg::PEND_W'(1);
					collect_byte = 1'b0;
					rx_bits = '0;
				end
				i2cbs_pkg::REQ_READ: begin
					for (int i = 0; i < i2cbs_pkg::BITS_PER_BYTE; i++) begin
						pin(1'b0, 1'b0, 1'b0);
						pin(1'b1, 1'b0, 1'b0);
						add(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
						pin(1'b0, 1'b0, 1'b0);
					end
					pin(1'b0, c.send_ack, 1'b0);
					pin(1'b1, c.send_ack, 1'b0);
					pin(1'b0, c.send_ack, 1'b1);
					samples_left = i2cbs_pkg::PEND_W'(i2cbs_pkg::BITS_PER_BYTE);
					collect_byte = 1'b1;
					rx_bits = '0;
				end
				i2cbs_pkg::REQ_SAMPLE: begin
					if (samples_left == '0)
						return 1'b0;
					if (collect_byte) begin
						rx_bits = {rx_bits[6:0], c.sda_level};
						samples_left = samples_left - i2cbs_pkg::PEND_W'(1);
						if (samples_left == '0)
							add(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, rx_bits, 1'b0);
					end else begin
						samples_left = '0;
						add(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, ~c.sda_level);
					end
				end
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		function string show(i2cbs_pkg::step_t s);
			return $sformatf("scl=%b sda_low=%b smp=%b last=%b rxv=%b byte=%h ack=%b",
				s.scl_level, s.sda_pull_low, s.sample_request, s.step_last,
				s.rx_valid, s.rx_byte, s.ack_seen);
		endfunction

		function void check_step(i2cbs_pkg::step_t got);
			i2cbs_pkg::step_t want;
			string bad;
			if (steps_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected step transaction: %s", show(got));
				return;
			end
			want = steps_due.pop_front();
			bad = "";
			if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
			if (got.sda_pull_low !== want.sda_pull_low) bad = {bad, " sda_pull_low"};
			if (got.sample_request !== want.sample_request) bad = {bad, " sample_request"};
			if (got.step_last !== want.step_last) bad = {bad, " step_last"};
			if (got.rx_valid !== want.rx_valid) bad = {bad, " rx_valid"};
			if (got.rx_byte !== want.rx_byte) bad = {bad, " rx_byte"};
			if (got.ack_seen !== want.ack_seen) bad = {bad, " ack_seen"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("Step mismatch in%s: expected %s, got %s", bad, show(want),
						show(got));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	i2cbs_pkg::cmd_t cmd = '0;
	logic step_valid;
	logic step_stall = 1'b0;
	i2cbs_pkg::step_t step;

	i2c_step_checker board;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int live_items = 0;

	i2c_master_bit_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.step_valid(step_valid),
		.step_stall(step_stall),
		.step(step)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				step_stall <= 1'b1;
			end else begin
				step_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && step_valid === 1'b1 && step_stall === 1'b0)
				board.check_step(step);
		end
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic i2cbs_pkg::cmd_t cmd_of(logic [2:0] req, logic [7:0] data, bit ack,
			bit sda);
		i2cbs_pkg::cmd_t c;
		c.req_type = req;
		c.data_byte = data;
		c.send_ack = ack;
		c.sda_level = sda;
		return c;
	endfunction

	function automatic i2cbs_pkg::cmd_t rand_cmd(logic [2:0] req);
		return cmd_of(req, 8'($urandom_range(255)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endfunction

	task automatic issue(i2cbs_pkg::cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
		if (board.expand_command(c))
			live_items++;
	endtask

	task automatic issue_sample(bit sda);
		i2cbs_pkg::cmd_t c;
		c = rand_cmd(i2cbs_pkg::REQ_SAMPLE);
		c.sda_level = sda;
		issue(c);
	endtask

	task automatic maybe_noise();
		if ($urandom_range(9) == 0)
			issue(rand_cmd(3'($urandom_range(7))));
	endtask

	task automatic write_acked();
		issue(rand_cmd(i2cbs_pkg::REQ_WRITE));
		issue_sample($urandom_range(3) == 0);
	endtask

	task automatic read_byte();
		int mode;
		int count;
		logic [7:0] bits;
		mode = int'($urandom_range(4));
		bits = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom_range(255));
		count = ($urandom_range(19) == 0) ? int'($urandom_range(7))
			: i2cbs_pkg::BITS_PER_BYTE;
		issue(rand_cmd(i2cbs_pkg::REQ_READ));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(49) == 0)
				maybe_noise();
			issue_sample(bits[7 - i]);
		end
	endtask

	task automatic random_items(int n);
		int target;
		target = live_items + n;
		while (live_items < target) begin
			maybe_noise();
			issue(rand_cmd(($urandom_range(3) == 0) ? i2cbs_pkg::REQ_RSTART
				: i2cbs_pkg::REQ_START));
			write_acked();
			repeat ($urandom_range(1, 4)) begin
				maybe_noise();
				if ($urandom_range(1))
					write_acked();
				else
					read_byte();
			end
			maybe_noise();
			issue(rand_cmd(i2cbs_pkg::REQ_STOP));
		end
	endtask

	initial begin
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 87, 0, 20};
		stall_set = '{0, 0, 87, 20};
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(cmd_of(i2cbs_pkg::REQ_START, 8'hFF, 1'b1, 1'b1));
		issue(cmd_of(i2cbs_pkg::REQ_RSTART, 8'h00, 1'b0, 1'b0));
		issue(cmd_of(i2cbs_pkg::REQ_STOP, 8'hFF, 1'b1, 1'b1));
		issue(cmd_of(i2cbs_pkg::REQ_WRITE, 8'hFF, 1'b0, 1'b1));
		issue_sample(1'b0);
		issue(cmd_of(i2cbs_pkg::REQ_WRITE, 8'h00, 1'b1, 1'b0));
		issue_sample(1'b1);
		// A sample with nothing outstanding must be dropped.
		issue_sample(1'b0);
		issue(cmd_of(i2cbs_pkg::REQ_READ, 8'h00, 1'b0, 1'b0));
		issue_sample(1'b1);
		issue_sample(1'b0);
		issue_sample(1'b1);
		// A start in the middle of a byte leaves the collection running.
		issue(cmd_of(i2cbs_pkg::REQ_START, 8'h00, 1'b0, 1'b0));
		issue_sample(1'b1);
		issue_sample(1'b1);
		issue_sample(1'b0);
		issue_sample(1'b0);
		issue_sample(1'b1);
		issue(cmd_of(i2cbs_pkg::REQ_READ, 8'hFF, 1'b1, 1'b1));
		issue_sample(1'b0);
		issue_sample(1'b1);
		// A write abandons the partial byte and waits for its own ACK.
		issue(cmd_of(i2cbs_pkg::REQ_WRITE, 8'hA5, 1'b0, 1'b1));
		issue_sample(1'b0);
		issue(cmd_of(REQ_SPARE_LO, 8'hFF, 1'b1, 1'b1));
		issue(cmd_of(REQ_SPARE_HI, 8'h00, 1'b0, 1'b0));

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			random_items(95);
		end

		// Hold the output off so the block backs up into the command port.
		idle_pct = 0;
		stall_pct = 20;
		hold_left = 400;
		random_items(30);
		cmd_valid <= 1'b0;

		while (board.steps_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
